FILE: hw/rtl/lkv_pkg.sv
// Shared types and constants for the LRU key-value cache.
// No dependencies; the interface files and the cache refer to this package by scoped names.
`timescale 1ns / 1ps
`default_nettype none

package lkv_pkg;

	// Width of the key, value and evicted key fields on the channels
	localparam int FIELD_W = 32;

	// Capacity register
	localparam int            CAP_W     = 5;
	localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

	// Request operations
	localparam logic CMD_GET = 1'b0;
	localparam logic CMD_PUT = 1'b1;

endpackage

`default_nettype wire

FILE: hw/rtl/lkv_cfg_if.sv
// Configuration write channel: valid, ready and the capacity write data.
// Depends on lkv_pkg for the register width.
`timescale 1ns / 1ps
`default_nettype none

interface lkv_cfg_if;
	logic                        valid;
	logic                        ready;
	logic [lkv_pkg::CAP_W-1:0]   data;

	modport source (output valid, data, input ready);
	modport sink   (input valid, data, output ready);
endinterface

`default_nettype wire

FILE: hw/rtl/lkv_req_if.sv
// Request channel: valid, ready and one get or put item.
// Depends on lkv_pkg for the field widths.
`timescale 1ns / 1ps
`default_nettype none

interface lkv_req_if;
	logic                               valid;
	logic                               ready;
	logic                               cmd;
	logic signed [lkv_pkg::FIELD_W-1:0] key;
	logic signed [lkv_pkg::FIELD_W-1:0] value;

	modport source (output valid, cmd, key, value, input ready);
	modport sink   (input valid, cmd, key, value, output ready);
endinterface

`default_nettype wire

FILE: hw/rtl/lkv_rsp_if.sv
// Response channel: valid, ready and one result item.
// Depends on lkv_pkg for the field widths.
`timescale 1ns / 1ps
`default_nettype none

interface lkv_rsp_if;
	logic                               valid;
	logic                               ready;
	logic                               found;
	logic signed [lkv_pkg::FIELD_W-1:0] read_value;
	logic                               evicted;
	logic signed [lkv_pkg::FIELD_W-1:0] evicted_key;

	modport source (output valid, found, read_value, evicted, evicted_key, input ready);
	modport sink   (input valid, found, read_value, evicted, evicted_key, output ready);
endinterface

`default_nettype wire

FILE: hw/rtl/lkv_ram.sv
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

module lkv_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 16
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// Write and read, read data registered
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

`default_nettype wire

FILE: hw/rtl/lru_key_value_cache.sv
// Every item takes one sweep over the key and rank memories, which finds the hit, the
// least recent entry and a free slot; every item but a get miss then takes a second
// read-modify-write sweep of the rank memory, which renumbers recency. One item at a
// time: the next is accepted only once the result is loaded into the output register.
// Reset: valid marks, entry count and state cleared at once, capacity set to 16; no sweep.
// Depends on lkv_pkg, lkv_cfg_if, lkv_req_if, lkv_rsp_if and lkv_ram.
`timescale 1ns / 1ps
`default_nettype none

module lru_key_value_cache #(
	parameter int ENTRIES    = 16,
	parameter int KEY_BITS   = 32,
	parameter int VALUE_BITS = 32
) (
	input  wire logic clk,
	input  wire logic arst_n,
	lkv_cfg_if.sink   cfg,
	lkv_req_if.sink   req,
	lkv_rsp_if.source rsp
);

	localparam int IDX_W = $clog2(ENTRIES);
	localparam int CNT_W = $clog2(ENTRIES + 1);
	localparam int CMP_W = (CNT_W > lkv_pkg::CAP_W) ? CNT_W : lkv_pkg::CAP_W;
	localparam int FW    = lkv_pkg::FIELD_W;
	localparam int KX    = (KEY_BITS > FW) ? KEY_BITS : FW;
	localparam int VX    = (VALUE_BITS > FW) ? VALUE_BITS : FW;
	localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(ENTRIES - 1);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SCAN,
		ST_UPD,
		ST_RANK,
		ST_DONE
	} state_t;

	state_t st_q;

	// Control registers
	logic [lkv_pkg::CAP_W-1:0] cap_q;
	logic [ENTRIES-1:0]        valid_q;
	logic [CNT_W-1:0]          cnt_q;
	logic                      sweep_on_q;
	logic [IDX_W-1:0]          sweep_q;
	logic                      sw_vld_s1;
	logic [IDX_W-1:0]          sw_idx_s1;
	logic                      hit_q;
	logic                      lru_have_q;
	logic                      free_have_q;
	logic                      out_vld_q;

	// Item and scan results
	logic                      cmd_q;
	logic [KEY_BITS-1:0]       key_q;
	logic [VALUE_BITS-1:0]     val_q;
	logic [IDX_W-1:0]          hit_idx_q;
	logic [IDX_W-1:0]          hit_rank_q;
	logic [IDX_W-1:0]          lru_idx_q;
	logic [IDX_W-1:0]          lru_rank_q;
	logic [KEY_BITS-1:0]       lru_key_q;
	logic [IDX_W-1:0]          free_idx_q;
	logic [IDX_W-1:0]          target_q;
	logic                      mode_all_q;
	logic                      res_found_q;
	logic                      res_ev_q;
	logic                      res_get_hit_q;
	logic [KEY_BITS-1:0]       res_evk_q;

	// Output register
	logic                      found_q;
	logic [FW-1:0]             rdv_q;
	logic                      ev_q;
	logic [FW-1:0]             evk_q;

	// Memory ports
	logic [KEY_BITS-1:0]       key_rdata;
	logic [VALUE_BITS-1:0]     val_rdata;
	logic [IDX_W-1:0]          rank_rdata;
	logic                      key_we;
	logic                      val_we;
	logic                      rank_we;
	logic [IDX_W-1:0]          rank_wdata;

	// Handshakes
	logic in_acc;
	logic load_out;
	assign cfg.ready = 1'b1;
	assign req.ready = (st_q == ST_IDLE);
	assign in_acc    = req.valid && req.ready;
	assign load_out  = (st_q == ST_DONE) && (!out_vld_q || rsp.ready);

	// Fit the request key and value to the stored widths
	logic [KX-1:0] key_ext;
	logic [VX-1:0] val_ext;
	assign key_ext = KX'(req.key);
	assign val_ext = VX'(req.value);

	// Scan compare on the entry just read
	logic scan_v;
	logic scan_match;
	logic scan_lru;
	assign scan_v     = valid_q[sw_idx_s1];
	assign scan_match = scan_v && (key_rdata == key_q);
	assign scan_lru   = scan_v && (!lru_have_q || (rank_rdata > lru_rank_q));

	// Decide the update from the scan results
	logic [CMP_W-1:0] cap_ext;
	logic [CMP_W-1:0] ent_ext;
	logic [CMP_W-1:0] eff_cap;
	logic             full;
	logic             is_put;
	logic             do_insert;
	logic             do_evict;
	logic [IDX_W-1:0] tgt;
	assign cap_ext   = CMP_W'(cap_q);
	assign ent_ext   = CMP_W'(ENTRIES);
	assign eff_cap   = (cap_ext == '0) ? CMP_W'(1) : ((cap_ext > ent_ext) ? ent_ext : cap_ext);
	assign full      = CMP_W'(cnt_q) >= eff_cap;
	assign is_put    = (cmd_q == lkv_pkg::CMD_PUT);
	assign do_insert = is_put && !hit_q;
	assign do_evict  = do_insert && full;
	assign tgt       = hit_q ? hit_idx_q : (full ? lru_idx_q : free_idx_q);

	// Renumber one rank: target becomes most recent, others age as needed
	always_comb begin
		if (sw_idx_s1 == target_q) begin
			rank_wdata = '0;
		end else if (valid_q[sw_idx_s1] && (mode_all_q || (rank_rdata < hit_rank_q))) begin
			rank_wdata = rank_rdata + IDX_W'(1);
		end else begin
			rank_wdata = rank_rdata;
		end
	end

	assign key_we  = (st_q == ST_UPD) && do_insert;
	assign val_we  = (st_q == ST_UPD) && is_put;
	assign rank_we = (st_q == ST_RANK) && sw_vld_s1;

	lkv_ram #(.WIDTH(KEY_BITS), .DEPTH(ENTRIES)) u_key_ram (
		.clk   (clk),
		.we    (key_we),
		.waddr (tgt),
		.wdata (key_q),
		.raddr (sweep_q),
		.rdata (key_rdata)
	);

	lkv_ram #(.WIDTH(VALUE_BITS), .DEPTH(ENTRIES)) u_val_ram (
		.clk   (clk),
		.we    (val_we),
		.waddr (tgt),
		.wdata (val_q),
		.raddr (hit_idx_q),
		.rdata (val_rdata)
	);

	lkv_ram #(.WIDTH(IDX_W), .DEPTH(ENTRIES)) u_rank_ram (
		.clk   (clk),
		.we    (rank_we),
		.waddr (sw_idx_s1),
		.wdata (rank_wdata),
		.raddr (sweep_q),
		.rdata (rank_rdata)
	);

	// Fit stored words to the output fields
	logic [KX-1:0] evk_ext;
	logic [VX-1:0] rdv_ext;
	assign evk_ext = KX'(res_evk_q);
	assign rdv_ext = VX'(val_rdata);

	// State, sweep control, valid marks, count, capacity and output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q        <= ST_IDLE;
			cap_q       <= lkv_pkg::CAP_RESET;
			valid_q     <= '0;
			cnt_q       <= '0;
			sweep_on_q  <= 1'b0;
			sweep_q     <= '0;
			sw_vld_s1   <= 1'b0;
			sw_idx_s1   <= '0;
			hit_q       <= 1'b0;
			lru_have_q  <= 1'b0;
			free_have_q <= 1'b0;
			out_vld_q   <= 1'b0;
		end else begin
			if (cfg.valid && cfg.ready) begin
				cap_q <= cfg.data;
			end

			// Advance the memory sweep
			sw_vld_s1 <= sweep_on_q;
			sw_idx_s1 <= sweep_q;
			if (sweep_on_q) begin
				sweep_q <= sweep_q + IDX_W'(1);
				if (sweep_q == LAST_IDX) begin
					sweep_on_q <= 1'b0;
				end
			end

			unique case (st_q)
				ST_IDLE: begin
					if (in_acc) begin
						st_q        <= ST_SCAN;
						sweep_q     <= '0;
						sweep_on_q  <= 1'b1;
						hit_q       <= 1'b0;
						lru_have_q  <= 1'b0;
						free_have_q <= 1'b0;
					end
				end
				ST_SCAN: begin
					if (sw_vld_s1) begin
						if (scan_match) begin
							hit_q <= 1'b1;
						end
						if (scan_lru) begin
							lru_have_q <= 1'b1;
						end
						if (!scan_v) begin
							free_have_q <= 1'b1;
						end
						if (sw_idx_s1 == LAST_IDX) begin
							st_q <= ST_UPD;
						end
					end
				end
				ST_UPD: begin
					if (do_insert) begin
						valid_q[tgt] <= 1'b1;
						if (!full) begin
							cnt_q <= cnt_q + CNT_W'(1);
						end
					end
					if (hit_q || is_put) begin
						st_q       <= ST_RANK;
						sweep_q    <= '0;
						sweep_on_q <= 1'b1;
					end else begin
						st_q <= ST_DONE;
					end
				end
				ST_RANK: begin
					if (sw_vld_s1 && (sw_idx_s1 == LAST_IDX)) begin
						st_q <= ST_DONE;
					end
				end
				ST_DONE: begin
					if (load_out) begin
						st_q <= ST_IDLE;
					end
				end
				default: begin
					st_q <= ST_IDLE;
				end
			endcase

			// Hold the result until taken
			if (load_out) begin
				out_vld_q <= 1'b1;
			end else if (rsp.ready) begin
				out_vld_q <= 1'b0;
			end
		end
	end

	// Item, scan results and output payload
	always_ff @(posedge clk) begin
		if (in_acc) begin
			cmd_q <= req.cmd;
			key_q <= key_ext[KEY_BITS-1:0];
			val_q <= val_ext[VALUE_BITS-1:0];
		end
		if ((st_q == ST_SCAN) && sw_vld_s1) begin
			if (scan_match) begin
				hit_idx_q  <= sw_idx_s1;
				hit_rank_q <= rank_rdata;
			end
			if (scan_lru) begin
				lru_idx_q  <= sw_idx_s1;
				lru_rank_q <= rank_rdata;
				lru_key_q  <= key_rdata;
			end
			if (!scan_v && !free_have_q) begin
				free_idx_q <= sw_idx_s1;
			end
		end
		if (st_q == ST_UPD) begin
			target_q      <= tgt;
			mode_all_q    <= !hit_q;
			res_found_q   <= hit_q;
			res_ev_q      <= do_evict;
			res_evk_q     <= do_evict ? lru_key_q : '0;
			res_get_hit_q <= hit_q && !is_put;
		end
		if (load_out) begin
			found_q <= res_found_q;
			rdv_q   <= res_get_hit_q ? rdv_ext[FW-1:0] : '0;
			ev_q    <= res_ev_q;
			evk_q   <= evk_ext[FW-1:0];
		end
	end

	assign rsp.valid       = out_vld_q;
	assign rsp.found       = found_q;
	assign rsp.read_value  = rdv_q;
	assign rsp.evicted     = ev_q;
	assign rsp.evicted_key = evk_q;

	// The count tracks the valid marks
	a_cnt_matches: assert property (@(posedge clk) disable iff (!arst_n)
		$countones(valid_q) == int'(cnt_q))
		else $error("entry count differs from number of valid entries");

	// The count never exceeds the store
	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		int'(cnt_q) <= ENTRIES)
		else $error("entry count above ENTRIES");

	// An eviction comes only from a put of a new key into a full store
	a_evict_put: assert property (@(posedge clk) disable iff (!arst_n)
		(st_q == ST_UPD) && do_evict |-> is_put && !hit_q && lru_have_q)
		else $error("eviction without a put miss on a full store");

endmodule

`default_nettype wire
